// File: hw/rtl/kdtl_pkg.sv
// ----------------------------------------------------------------------------
// Keyword/date token lexer package
// Shared widths, token kind codes, character codes and keyword tables.
// ----------------------------------------------------------------------------
package kdtl_pkg;

    localparam int POSITION_BITS = 16;
    localparam int KW_COUNT      = 9;

    localparam logic [4:0] KIND_STRING  = 5'd9;
    localparam logic [4:0] KIND_INT     = 5'd10;
    localparam logic [4:0] KIND_DATE    = 5'd11;
    localparam logic [4:0] KIND_LBRACE  = 5'd12;
    localparam logic [4:0] KIND_RBRACE  = 5'd13;
    localparam logic [4:0] KIND_LBRACK  = 5'd14;
    localparam logic [4:0] KIND_RBRACK  = 5'd15;
    localparam logic [4:0] KIND_COLON   = 5'd16;
    localparam logic [4:0] KIND_COMMA   = 5'd17;
    localparam logic [4:0] KIND_SEMI    = 5'd18;
    localparam logic [4:0] KIND_UNKNOWN = 5'd19;
    localparam logic [4:0] KIND_END     = 5'd20;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Keywords are left-justified in 12 characters; the first character is
    // the top byte.
    localparam logic [95:0] KW_TEXT [KW_COUNT] = '{
        "TABLERO     ",
        "COLUMNA     ",
        "tarea       ",
        "prioridad   ",
        "responsable ",
        {"fecha", "_", "limite"},
        "ALTA        ",
        "MEDIA       ",
        "BAJA        "
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd7, 4'd7, 4'd5, 4'd9, 4'd11, 4'd12, 4'd4, 4'd5, 4'd4
    };

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [15:0] start_line;
        logic [15:0] start_col;
        logic        last;
    } t_result;

endpackage

// File: hw/rtl/kdtl_in_if.sv
// ----------------------------------------------------------------------------
// Lexer input channel
// One source character or an end-of-input mark per transfer.
// ----------------------------------------------------------------------------
interface kdtl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_input;

    modport source (output valid, output ch, output end_of_input, input ready);
    modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

// File: hw/rtl/kdtl_out_if.sv
// ----------------------------------------------------------------------------
// Lexer output channel
// One token with its kind and start position per transfer.
// ----------------------------------------------------------------------------
interface kdtl_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [15:0] start_line;
    logic [15:0] start_col;
    logic        last;

    modport source (output valid, output token_kind, output start_line,
                    output start_col, output last, input ready);
    modport sink   (input valid, input token_kind, input start_line,
                    input start_col, input last, output ready);
endinterface

// File: hw/rtl/keyword_date_token_lexer.sv
// ----------------------------------------------------------------------------
// Keyword/date token lexer
// Flow: a transferred character is held in an input register and then scanned;
// its tokens are written to the output buffer as it is scanned.
// Throughput: one character per cycle; tokens leave at one per cycle while the
// receiver is ready, from a four-entry output buffer, which stalls the input
// only when it cannot take two more tokens.
// Reset: scanner in the initial state at line 1, column 1, buffer empty.
// ----------------------------------------------------------------------------
module keyword_date_token_lexer
    import kdtl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    kdtl_in_if.sink           i_in,
    kdtl_out_if.source        o_out
);

    typedef enum logic [7:0] {
        M_INIT    = 8'b0000_0001,
        M_IDENT   = 8'b0000_0010,
        M_STR     = 8'b0000_0100,
        M_NUM     = 8'b0000_1000,
        M_MONTH   = 8'b0001_0000,
        M_DAY     = 8'b0010_0000,
        M_SLASH   = 8'b0100_0000,
        M_COMMENT = 8'b1000_0000
    } t_mode;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [15:0] pos16(input logic [POSITION_BITS-1:0] p);
        logic [31:0] wide;
        wide = 32'(p);
        return wide[15:0];
    endfunction

    function automatic logic [8:0] hits_after(input logic [8:0] hits, input logic [3:0] len,
                                              input logic [7:0] c);
        logic [8:0] res;
        logic [3:0] pos;
        res = hits;
        pos = 4'd11 - len;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (len >= KW_LEN[k]) begin
                res[k] = 1'b0;
            end else if (KW_TEXT[k][{pos, 3'b000} +: 8] != c) begin
                res[k] = 1'b0;
            end
        end
        return res;
    endfunction

    function automatic logic [4:0] delim_kind(input logic [7:0] c);
        logic [4:0] kind;
        unique case (c)
            CH_LBRACE: kind = KIND_LBRACE;
            CH_RBRACE: kind = KIND_RBRACE;
            CH_LBRACK: kind = KIND_LBRACK;
            CH_RBRACK: kind = KIND_RBRACK;
            CH_COLON:  kind = KIND_COLON;
            CH_COMMA:  kind = KIND_COMMA;
            CH_SEMI:   kind = KIND_SEMI;
            default:   kind = KIND_UNKNOWN;
        endcase
        return kind;
    endfunction

    logic                     r_in_vld;
    logic [7:0]               r_in_ch;
    logic                     r_in_eoi;

    t_mode                    r_mode, n_mode;
    logic [POSITION_BITS-1:0] r_cur_line, n_cur_line;
    logic [POSITION_BITS-1:0] r_cur_col, n_cur_col;
    logic [15:0]              r_tok_line, n_tok_line;
    logic [15:0]              r_tok_col, n_tok_col;
    logic [2:0]               r_dc, n_dc;
    logic [8:0]               r_hits, n_hits;
    logic [3:0]               r_len, n_len;

    t_result                  r_buf [4];
    logic [1:0]               r_wr_ptr;
    logic [1:0]               r_rd_ptr;
    logic [2:0]               r_count;

    logic                     w_step;
    logic                     w_pop;
    logic [1:0]               w_push;
    logic [4:0]               w_ident_kind;
    logic                     emit_a, emit_b, again;
    logic [4:0]               kind_a, kind_b;
    logic [15:0]              cur_line16, cur_col16;
    t_result                  w_res0, w_res1;

    assign w_step      = r_in_vld && (r_count <= 3'd2);
    assign i_in.ready  = !r_in_vld || w_step;
    assign w_pop       = (r_count != 3'd0) && o_out.ready;
    assign cur_line16  = pos16(r_cur_line);
    assign cur_col16   = pos16(r_cur_col);

    always_comb begin
        w_ident_kind = KIND_UNKNOWN;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (r_hits[k] && KW_LEN[k] == r_len) begin
                w_ident_kind = 5'(k);
            end
        end
    end

    always_comb begin
        n_mode     = r_mode;
        n_cur_line = r_cur_line;
        n_cur_col  = r_cur_col;
        n_tok_line = r_tok_line;
        n_tok_col  = r_tok_col;
        n_dc       = r_dc;
        n_hits     = r_hits;
        n_len      = r_len;
        emit_a     = 1'b0;
        kind_a     = KIND_UNKNOWN;
        emit_b     = 1'b0;
        kind_b     = KIND_UNKNOWN;
        again      = 1'b0;
        if (r_in_eoi) begin
            unique case (r_mode)
                M_IDENT: begin
                    emit_a = 1'b1;
                    kind_a = w_ident_kind;
                end
                M_STR, M_SLASH: begin
                    emit_a = 1'b1;
                    kind_a = KIND_UNKNOWN;
                end
                M_NUM, M_MONTH: begin
                    emit_a = 1'b1;
                    kind_a = KIND_INT;
                end
                M_DAY: begin
                    emit_a = 1'b1;
                    kind_a = (r_dc == 3'd2) ? KIND_DATE : KIND_INT;
                end
                default: begin
                end
            endcase
            emit_b = 1'b1;
            kind_b = KIND_END;
            n_mode = M_INIT;
        end else begin
            unique case (r_mode)
                M_IDENT: begin
                    if (is_letter(r_in_ch) || is_digit(r_in_ch)) begin
                        n_hits = hits_after(r_hits, r_len, r_in_ch);
                        n_len  = (r_len < 4'd15) ? r_len + 4'd1 : r_len;
                    end else begin
                        emit_a = 1'b1;
                        kind_a = w_ident_kind;
                        again  = 1'b1;
                    end
                end
                M_STR: begin
                    if (r_in_ch == CH_QUOTE) begin
                        emit_a = 1'b1;
                        kind_a = KIND_STRING;
                        n_mode = M_INIT;
                    end else if (r_in_ch == CH_LF || r_in_ch == CH_NUL) begin
                        emit_a = 1'b1;
                        kind_a = KIND_UNKNOWN;
                        again  = 1'b1;
                    end
                end
                M_NUM: begin
                    if (is_digit(r_in_ch)) begin
                        n_dc = (r_dc < 3'd7) ? r_dc + 3'd1 : r_dc;
                    end else if (r_in_ch == CH_DASH && r_dc == 3'd4) begin
                        n_mode = M_MONTH;
                        n_dc   = 3'd0;
                    end else begin
                        emit_a = 1'b1;
                        kind_a = KIND_INT;
                        again  = 1'b1;
                    end
                end
                M_MONTH: begin
                    if (is_digit(r_in_ch) && r_dc < 3'd2) begin
                        n_dc = r_dc + 3'd1;
                    end else if (r_dc == 3'd2 && r_in_ch == CH_DASH) begin
                        n_mode = M_DAY;
                        n_dc   = 3'd0;
                    end else begin
                        emit_a = 1'b1;
                        kind_a = KIND_INT;
                        again  = 1'b1;
                    end
                end
                M_DAY: begin
                    if (is_digit(r_in_ch) && r_dc < 3'd2) begin
                        n_dc = r_dc + 3'd1;
                    end else begin
                        emit_a = 1'b1;
                        kind_a = (r_dc == 3'd2 && !is_digit(r_in_ch)) ? KIND_DATE : KIND_INT;
                        again  = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (r_in_ch == CH_SLASH) begin
                        n_mode = M_COMMENT;
                    end else begin
                        emit_a = 1'b1;
                        kind_a = KIND_UNKNOWN;
                        again  = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (r_in_ch == CH_LF) begin
                        again = 1'b1;
                    end
                end
                default: begin
                    again = 1'b1;
                end
            endcase

            if (again) begin
                n_mode = M_INIT;
                if (r_in_ch == CH_SPACE || r_in_ch == CH_TAB || r_in_ch == CH_CR
                        || r_in_ch == CH_LF) begin
                    n_mode = M_INIT;
                end else if (r_in_ch == CH_SLASH) begin
                    n_tok_line = cur_line16;
                    n_tok_col  = cur_col16;
                    n_mode     = M_SLASH;
                end else if (is_letter(r_in_ch)) begin
                    n_tok_line = cur_line16;
                    n_tok_col  = cur_col16;
                    n_mode     = M_IDENT;
                    n_hits     = hits_after(9'h1FF, 4'd0, r_in_ch);
                    n_len      = 4'd1;
                end else if (r_in_ch == CH_QUOTE) begin
                    n_tok_line = cur_line16;
                    n_tok_col  = cur_col16;
                    n_mode     = M_STR;
                end else if (is_digit(r_in_ch)) begin
                    n_tok_line = cur_line16;
                    n_tok_col  = cur_col16;
                    n_mode     = M_NUM;
                    n_dc       = 3'd1;
                end else begin
                    emit_b = 1'b1;
                    kind_b = delim_kind(r_in_ch);
                end
            end

            if (r_in_ch == CH_LF) begin
                if (r_cur_line < POS_MAX) begin
                    n_cur_line = r_cur_line + POSITION_BITS'(1);
                end
                n_cur_col = POSITION_BITS'(1);
            end else if (r_cur_col < POS_MAX) begin
                n_cur_col = r_cur_col + POSITION_BITS'(1);
            end
        end
    end

    assign w_push = {1'b0, emit_a} + {1'b0, emit_b};

    always_comb begin
        w_res0.token_kind = emit_a ? kind_a : kind_b;
        w_res0.start_line = emit_a ? r_tok_line : cur_line16;
        w_res0.start_col  = emit_a ? r_tok_col : cur_col16;
        w_res0.last       = (w_push == 2'd1);
        w_res1.token_kind = kind_b;
        w_res1.start_line = cur_line16;
        w_res1.start_col  = cur_col16;
        w_res1.last       = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_mode     <= M_INIT;
            r_cur_line <= POSITION_BITS'(1);
            r_cur_col  <= POSITION_BITS'(1);
            r_dc       <= 3'd0;
            r_hits     <= 9'd0;
            r_len      <= 4'd0;
            r_wr_ptr   <= 2'd0;
            r_rd_ptr   <= 2'd0;
            r_count    <= 3'd0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (w_step) begin
                r_mode     <= n_mode;
                r_cur_line <= n_cur_line;
                r_cur_col  <= n_cur_col;
                r_dc       <= n_dc;
                r_hits     <= n_hits;
                r_len      <= n_len;
                r_wr_ptr   <= r_wr_ptr + w_push;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + (w_step ? {1'b0, w_push} : 3'd0) - {2'b00, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_ch  <= i_in.ch;
            r_in_eoi <= i_in.end_of_input;
        end
        if (w_step) begin
            r_tok_line <= n_tok_line;
            r_tok_col  <= n_tok_col;
            if (w_push != 2'd0) begin
                r_buf[r_wr_ptr] <= w_res0;
            end
            if (w_push == 2'd2) begin
                r_buf[r_wr_ptr + 2'd1] <= w_res1;
            end
        end
    end

    assign o_out.valid      = (r_count != 3'd0);
    assign o_out.token_kind = r_buf[r_rd_ptr].token_kind;
    assign o_out.start_line = r_buf[r_rd_ptr].start_line;
    assign o_out.start_col  = r_buf[r_rd_ptr].start_col;
    assign o_out.last       = r_buf[r_rd_ptr].last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("output buffer count out of range");

    a_eoi_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_in_eoi) |-> (w_push != 2'd0))
        else $error("end of input produced no end token");

    a_eoi_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_in_eoi) |=> (r_mode == M_INIT))
        else $error("scanner not back in initial state after end of input");

    a_line_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> (r_cur_line >= $past(r_cur_line)))
        else $error("line counter went backwards");

endmodule

// File: tb/sv/keyword_date_token_lexer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keyword/date token lexer testbench
// Streams source bytes and end-of-input marks through the lexer. A behavioral
// scanner in the bench predicts each random-part token with its kind and start
// position, and each output transfer is compared against the oldest expected
// token. A short fixed script, its tokens taken from a table, comes first.
// Random token sequences and noise follow, each closed by a short fixed line,
// with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module keyword_date_token_lexer_tb;
    import kdtl_pkg::*;

    localparam int  CLK_PERIOD   = 8;
    localparam int  RANDOM_ITEMS = 750;
    localparam time RUN_LIMIT    = 30_000_000;

    localparam logic [7:0] DELIMS [7] = '{
        CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_COLON, CH_COMMA, CH_SEMI
    };
    localparam logic [7:0] BLANKS [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

    typedef enum logic [2:0] {
        SCAN_START, SCAN_WORD, SCAN_STRING, SCAN_NUMBER,
        SCAN_MONTH, SCAN_DAY, SCAN_SLASH, SCAN_COMMENT
    } scan_state_e;

    typedef enum int {SINK_OPEN, SINK_HALF, SINK_SPARSE, SINK_HOLD} sink_mode_e;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
    } src_item_t;

    typedef struct {
        logic [7:0] ch;
        logic       eoi;
        int         nres;
        logic [4:0] kind_a;
        int         line_a;
        int         col_a;
        logic [4:0] kind_b;
        int         line_b;
        int         col_b;
    } lex_row_t;

    // Extreme bytes, an unclosed string, a lone slash, a failed date,
    // a comment and an end mark, all from a fresh reset.
    lex_row_t directed_rows [21] = '{
        '{CH_LBRACE, 1'b0, 1, KIND_LBRACE,  1, 1, '0, 0, 0},
        '{8'hFF,     1'b0, 1, KIND_UNKNOWN, 1, 2, '0, 0, 0},
        '{CH_QUOTE,  1'b0, 0, '0, 0, 0, '0, 0, 0},
        '{CH_NUL,    1'b0, 2, KIND_UNKNOWN, 1, 3, KIND_UNKNOWN, 1, 4},
        '{CH_SLASH,  1'b0, 0, '0, 0, 0, '0, 0, 0},
        '{CH_COMMA,  1'b0, 2, KIND_UNKNOWN, 1, 5, KIND_COMMA, 1, 6},
        '{CH_QUOTE,  1'b0, 0, '0, 0, 0, '0, 0, 0},
        '{CH_LF,     1'b0, 1, KIND_UNKNOWN, 1, 7, '0, 0, 0},
        '{"1",       1'b0, 0, '0, 0, 0, '0, 0, 0},
        '{"2",       1'b0, 0, '0, 0, 0, '0, 0, 0},
        '{"3",       1'b0, 0, '0, 0, 0, '0, 0, 0},
        '{"4",       1'b0, 0, '0, 0, 0, '0, 0, 0},
        '{CH_DASH,   1'b0, 0, '0, 0, 0, '0, 0, 0},
        '{"5",       1'b0, 0, '0, 0, 0, '0, 0, 0},
        '{"x",       1'b0, 1, KIND_INT, 2, 1, '0, 0, 0},
        '{CH_COLON,  1'b0, 2, KIND_UNKNOWN, 2, 7, KIND_COLON, 2, 8},
        '{CH_SLASH,  1'b0, 0, '0, 0, 0, '0, 0, 0},
        '{CH_SLASH,  1'b0, 0, '0, 0, 0, '0, 0, 0},
        '{CH_RBRACE, 1'b0, 0, '0, 0, 0, '0, 0, 0},
        '{CH_LF,     1'b0, 0, '0, 0, 0, '0, 0, 0},
        '{CH_LBRACE, 1'b1, 1, KIND_END, 3, 1, '0, 0, 0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    kdtl_in_if  lex_in ();
    kdtl_out_if lex_out ();

    keyword_date_token_lexer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (lex_in),
        .o_out   (lex_out)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Scanner state of the predictor.
    scan_state_e scan_state;
    logic [15:0] line_now, col_now, tok_line, tok_col;
    logic [2:0]  digits;
    logic [8:0]  kw_live;
    logic [3:0]  id_len;
    t_result     pred_tok [2];
    int          pred_n;

    t_result     token_q [$];
    src_item_t   stim_q [$];
    string       name_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";

    int          burst_left = 0;
    int          errors     = 0;
    int          n_chars    = 0;
    int          n_marks    = 0;
    int          n_checked  = 0;
    logic [20:0] kinds_seen = '0;
    logic [15:0] top_line   = '0;
    logic [15:0] top_col    = '0;

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void note_token(logic [4:0] kind, logic [15:0] ln, logic [15:0] cl);
        if (pred_n < 2) begin
            pred_tok[pred_n] = '{token_kind: kind, start_line: ln, start_col: cl, last: 1'b0};
            pred_n++;
        end
    endfunction

    function automatic void ident_push(logic [7:0] c);
        for (int k = 0; k < KW_COUNT; k++) begin
            if (id_len >= KW_LEN[k]) begin
                kw_live[k] = 1'b0;
            end else if (KW_TEXT[k][95 - 8 * int'(id_len) -: 8] != c) begin
                kw_live[k] = 1'b0;
            end
        end
        if (id_len != 4'd15) id_len++;
    endfunction

    function automatic logic [4:0] ident_kind();
        for (int k = 0; k < KW_COUNT; k++) begin
            if (kw_live[k] && KW_LEN[k] == id_len) return 5'(k);
        end
        return KIND_UNKNOWN;
    endfunction

    function automatic void restart_scan(logic [7:0] c);
        scan_state = SCAN_START;
        if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) return;
        if (c == CH_SLASH) begin
            tok_line = line_now;
            tok_col = col_now;
            scan_state = SCAN_SLASH;
        end else if (is_alpha(c)) begin
            tok_line = line_now;
            tok_col = col_now;
            scan_state = SCAN_WORD;
            kw_live = 9'h1FF;
            id_len = '0;
            ident_push(c);
        end else if (c == CH_QUOTE) begin
            tok_line = line_now;
            tok_col = col_now;
            scan_state = SCAN_STRING;
        end else if (is_num(c)) begin
            tok_line = line_now;
            tok_col = col_now;
            scan_state = SCAN_NUMBER;
            digits = 3'd1;
        end else begin
            case (c)
                CH_LBRACE: note_token(KIND_LBRACE, line_now, col_now);
                CH_RBRACE: note_token(KIND_RBRACE, line_now, col_now);
                CH_LBRACK: note_token(KIND_LBRACK, line_now, col_now);
                CH_RBRACK: note_token(KIND_RBRACK, line_now, col_now);
                CH_COLON:  note_token(KIND_COLON, line_now, col_now);
                CH_COMMA:  note_token(KIND_COMMA, line_now, col_now);
                CH_SEMI:   note_token(KIND_SEMI, line_now, col_now);
                default:   note_token(KIND_UNKNOWN, line_now, col_now);
            endcase
        end
    endfunction

    function automatic void lex_predict(logic [7:0] c, logic eoi);
        logic rescan;
        rescan = 1'b0;
        pred_n = 0;
        if (eoi) begin
            case (scan_state)
                SCAN_WORD:   note_token(ident_kind(), tok_line, tok_col);
                SCAN_STRING,
                SCAN_SLASH:  note_token(KIND_UNKNOWN, tok_line, tok_col);
                SCAN_NUMBER,
                SCAN_MONTH:  note_token(KIND_INT, tok_line, tok_col);
                SCAN_DAY:    note_token(digits == 3'd2 ? KIND_DATE : KIND_INT, tok_line, tok_col);
                default: ;
            endcase
            note_token(KIND_END, line_now, col_now);
            scan_state = SCAN_START;
        end else begin
            case (scan_state)
                SCAN_WORD: begin
                    if (is_alpha(c) || is_num(c)) begin
                        ident_push(c);
                    end else begin
                        note_token(ident_kind(), tok_line, tok_col);
                        rescan = 1'b1;
                    end
                end
                SCAN_STRING: begin
                    if (c == CH_QUOTE) begin
                        note_token(KIND_STRING, tok_line, tok_col);
                        scan_state = SCAN_START;
                    end else if (c == CH_LF || c == CH_NUL) begin
                        note_token(KIND_UNKNOWN, tok_line, tok_col);
                        rescan = 1'b1;
                    end
                end
                SCAN_NUMBER: begin
                    if (is_num(c)) begin
                        if (digits != 3'd7) digits++;
                    end else if (c == CH_DASH && digits == 3'd4) begin
                        scan_state = SCAN_MONTH;
                        digits = '0;
                    end else begin
                        note_token(KIND_INT, tok_line, tok_col);
                        rescan = 1'b1;
                    end
                end
                SCAN_MONTH: begin
                    if (is_num(c) && digits < 3'd2) begin
                        digits++;
                    end else if (digits == 3'd2 && c == CH_DASH) begin
                        scan_state = SCAN_DAY;
                        digits = '0;
                    end else begin
                        note_token(KIND_INT, tok_line, tok_col);
                        rescan = 1'b1;
                    end
                end
                SCAN_DAY: begin
                    if (is_num(c) && digits < 3'd2) begin
                        digits++;
                    end else if (digits == 3'd2 && !is_num(c)) begin
                        note_token(KIND_DATE, tok_line, tok_col);
                        rescan = 1'b1;
                    end else begin
                        note_token(KIND_INT, tok_line, tok_col);
                        rescan = 1'b1;
                    end
                end
                SCAN_SLASH: begin
                    if (c == CH_SLASH) begin
                        scan_state = SCAN_COMMENT;
                    end else begin
                        note_token(KIND_UNKNOWN, tok_line, tok_col);
                        rescan = 1'b1;
                    end
                end
                SCAN_COMMENT: rescan = (c == CH_LF);
                default:      rescan = 1'b1;
            endcase
            if (rescan) restart_scan(c);
            if (c == CH_LF) begin
                if (line_now != 16'hFFFF) line_now++;
                col_now = 16'd1;
            end else if (col_now != 16'hFFFF) begin
                col_now++;
            end
        end
        if (pred_n > 0) pred_tok[pred_n - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic int next_burst();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return $urandom_range(1, 8);
        if (r < 9) return $urandom_range(10, 40);
        return $urandom_range(100, 400);
    endfunction

    // Presents one item and returns at the edge where it transfers.
    task automatic offer_item(input logic [7:0] c, input logic e);
        int gap;
        if (burst_left == 0) begin
            lex_in.valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
            burst_left = next_burst();
        end
        lex_in.valid        <= 1'b1;
        lex_in.ch           <= c;
        lex_in.end_of_input <= e;
        @(posedge i_clk);
        while (lex_in.ready !== 1'b1) @(posedge i_clk);
        burst_left--;
        if (e) n_marks++;
        else n_chars++;
    endtask

    task automatic send_item(input src_item_t it);
        offer_item(it.ch, it.eoi);
        lex_predict(it.ch, it.eoi);
        for (int i = 0; i < pred_n; i++) token_q.insert(token_q.size(), pred_tok[i]);
    endtask

    task automatic run_stimulus();
        while (stim_q.size() != 0) send_item(stim_q.pop_front());
    endtask

    task automatic wait_for_tokens();
        lex_in.valid <= 1'b0;
        burst_left = 0;
        while (token_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic add_char(input logic [7:0] c);
        stim_q.insert(stim_q.size(), src_item_t'{ch: c, eoi: 1'b0});
    endtask

    task automatic add_end();
        stim_q.insert(stim_q.size(), src_item_t'{ch: 8'($urandom_range(0, 255)), eoi: 1'b1});
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_char(s[i]);
    endtask

    function automatic logic [7:0] rand_digit();
        return "0" + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_string_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_LF);
        return b;
    endfunction

    // Appends one random lexical unit, mostly well formed, sometimes broken.
    task automatic add_segment();
        int pick, len, k, cut;
        logic [7:0] d [10];
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
            k = $urandom_range(0, KW_COUNT - 1);
            for (int i = 0; i < KW_LEN[k]; i++) add_char(KW_TEXT[k][95 - 8 * i -: 8]);
            if ($urandom_range(0, 6) == 0) add_char(name_chars[$urandom_range(0, 52)]);
        end else if (pick < 22) begin
            if ($urandom_range(0, 1) == 0) begin
                k = $urandom_range(0, KW_COUNT - 1);
                len = $urandom_range(1, KW_LEN[k] - 1);
                for (int i = 0; i < len; i++) add_char(KW_TEXT[k][95 - 8 * i -: 8]);
            end else begin
                len = $urandom_range(1, 18);
                add_char(name_chars[$urandom_range(0, 52)]);
                for (int i = 1; i < len; i++) begin
                    if ($urandom_range(0, 3) == 0) add_char(rand_digit());
                    else add_char(name_chars[$urandom_range(0, 52)]);
                end
            end
        end else if (pick < 32) begin
            add_char(CH_QUOTE);
            len = $urandom_range(0, 6);
            for (int i = 0; i < len; i++) add_char(rand_string_byte());
            add_char(CH_QUOTE);
        end else if (pick < 37) begin
            add_char(CH_QUOTE);
            len = $urandom_range(0, 4);
            for (int i = 0; i < len; i++) add_char(rand_string_byte());
            case ($urandom_range(0, 2))
                0:       add_char(CH_LF);
                1:       add_char(CH_NUL);
                default: add_end();
            endcase
        end else if (pick < 47) begin
            len = $urandom_range(1, 9);
            for (int i = 0; i < len; i++) add_char(rand_digit());
        end else if (pick < 66) begin
            for (int i = 0; i < 10; i++) d[i] = rand_digit();
            d[4] = CH_DASH;
            d[7] = CH_DASH;
            if (pick < 57) begin
                for (int i = 0; i < 10; i++) add_char(d[i]);
            end else begin
                cut = $urandom_range(5, 10);
                for (int i = 0; i < cut; i++) add_char(d[i]);
                case ($urandom_range(0, 9))
                    0, 1, 2: add_char(rand_digit());
                    3, 4, 5: add_char(CH_DASH);
                    6:       add_end();
                    default: add_char(8'($urandom_range(0, 255)));
                endcase
            end
        end else if (pick < 77) begin
            add_char(DELIMS[$urandom_range(0, 6)]);
        end else if (pick < 84) begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++) add_char(BLANKS[$urandom_range(0, 3)]);
        end else if (pick < 89) begin
            add_char(CH_SLASH);
            add_char(CH_SLASH);
            len = $urandom_range(0, 10);
            for (int i = 0; i < len; i++) add_char(rand_string_byte());
            add_char(CH_LF);
        end else if (pick < 92) begin
            add_char(CH_SLASH);
        end else if (pick < 97) begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++) add_char(8'($urandom_range(0, 255)));
        end else begin
            add_end();
        end
        if ($urandom_range(0, 1) == 0) add_char(BLANKS[$urandom_range(0, 3)]);
    endtask

    initial begin : sink_pattern
        sink_mode_e mode;
        int span;
        mode = SINK_OPEN;
        span = 0;
        lex_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (span == 0) begin
                mode = sink_mode_e'($urandom_range(0, 3));
                span = (mode == SINK_HOLD) ? $urandom_range(2, 40) : $urandom_range(10, 120);
            end
            span--;
            case (mode)
                SINK_OPEN:   lex_out.ready <= 1'b1;
                SINK_HALF:   lex_out.ready <= 1'($urandom_range(0, 1));
                SINK_SPARSE: lex_out.ready <= ($urandom_range(0, 3) == 0);
                default:     lex_out.ready <= 1'b0;
            endcase
        end
    end

    always @(posedge i_clk) begin : token_check
        t_result want;
        if (i_rst_n === 1'b1 && lex_out.valid === 1'b1 && lex_out.ready === 1'b1) begin
            if (token_q.size() == 0) begin
                report_mismatch($sformatf("unexpected token kind %0d at %0d:%0d",
                                          lex_out.token_kind, lex_out.start_line,
                                          lex_out.start_col));
            end else begin
                want = token_q.pop_front();
                n_checked++;
                kinds_seen[want.token_kind] = 1'b1;
                if (want.start_line > top_line) top_line = want.start_line;
                if (want.start_col > top_col) top_col = want.start_col;
                if (lex_out.token_kind !== want.token_kind
                        || lex_out.start_line !== want.start_line
                        || lex_out.start_col !== want.start_col
                        || lex_out.last !== want.last) begin
                    report_mismatch($sformatf(
                        "token got kind %0d at %0d:%0d last %b, want kind %0d at %0d:%0d last %b",
                        lex_out.token_kind, lex_out.start_line, lex_out.start_col,
                        lex_out.last, want.token_kind, want.start_line, want.start_col,
                        want.last));
                end
            end
        end
    end

    initial begin : main_flow
        t_result want;
        i_rst_n             <= 1'b0;
        lex_in.valid        <= 1'b0;
        lex_in.ch           <= '0;
        lex_in.end_of_input <= 1'b0;
        scan_state = SCAN_START;
        line_now = 16'd1;
        col_now  = 16'd1;
        tok_line = '0;
        tok_col  = '0;
        digits   = '0;
        kw_live  = '0;
        id_len   = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            offer_item(directed_rows[r].ch, directed_rows[r].eoi);
            lex_predict(directed_rows[r].ch, directed_rows[r].eoi);
            if (directed_rows[r].nres > 0) begin
                want.token_kind = directed_rows[r].kind_a;
                want.start_line = 16'(directed_rows[r].line_a);
                want.start_col  = 16'(directed_rows[r].col_a);
                want.last       = (directed_rows[r].nres == 1);
                token_q.insert(token_q.size(), want);
            end
            if (directed_rows[r].nres > 1) begin
                want.token_kind = directed_rows[r].kind_b;
                want.start_line = 16'(directed_rows[r].line_b);
                want.start_col  = 16'(directed_rows[r].col_b);
                want.last       = 1'b1;
                token_q.insert(token_q.size(), want);
            end
        end
        wait_for_tokens();

        while (stim_q.size() < RANDOM_ITEMS / 2) add_segment();
        run_stimulus();
        wait_for_tokens();

        add_text("{BAJA 2026-12-31,\"x\" 12");
        add_char(CH_LF);
        run_stimulus();

        while (stim_q.size() < RANDOM_ITEMS / 2) add_segment();
        run_stimulus();

        add_text("ALTA:7;tarea 1999-01-0");
        add_end();
        run_stimulus();

        lex_in.valid <= 1'b0;
        while (token_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("Summary: %0d characters and %0d end marks sent, %0d tokens checked.",
                 n_chars, n_marks, n_checked);
        $display("Summary: %0d of 21 token kinds seen, start positions up to line %0d, col %0d.",
                 $countones(kinds_seen), top_line, top_col);
        if (errors == 0) begin
            $display("PASS keyword_date_token_lexer");
        end else begin
            $display("FAIL keyword_date_token_lexer");
        end
        $finish;
    end

    initial begin : run_limit
        #(RUN_LIMIT);
        $display("Timeout with %0d tokens outstanding.", token_q.size());
        $display("FAIL keyword_date_token_lexer");
        $finish;
    end

endmodule
